@@ hw/rtl/hog_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hog_pkg
// Shared constants, codes and types of the cell orientation histogram block.
// ---------------------------------------------------------------------------
package hog_pkg;

  localparam int CELL_SIZE   = 16;
  localparam int CELL_SHIFT  = $clog2(CELL_SIZE);
  localparam int MAX_CELLS_X = 16;
  localparam int MAX_CELLS_Y = 16;
  localparam int NUM_BINS    = 8;

  localparam int PIX_W     = 8;
  localparam int GRAD_W    = PIX_W + 1;
  localparam int CFG_W     = 5;
  localparam int LINE_W    = CELL_SIZE * MAX_CELLS_X;
  localparam int COL_W     = $clog2(LINE_W);
  localparam int ROW_W     = $clog2(CELL_SIZE * MAX_CELLS_Y);
  localparam int LINE_AW   = COL_W + 1;
  localparam int CELL_W    = $clog2(MAX_CELLS_X * MAX_CELLS_Y);
  localparam int OCT_W     = $clog2(NUM_BINS);
  localparam int BIN_AW    = CELL_W + OCT_W;
  localparam int BIN_DEPTH = MAX_CELLS_X * MAX_CELLS_Y * NUM_BINS;
  localparam int BIN_W     = 22;

  // magnitude: sqrt of (gx^2+gy^2)*256, 13 root bits, one bit per cycle
  localparam int SUMSQ_W = 2 * PIX_W + 1;
  localparam int SQRT_IT = 13;
  localparam int IT_W    = $clog2(SQRT_IT);
  localparam int RAD_W   = 2 * SQRT_IT;
  localparam int REM_W   = SQRT_IT + 3;
  localparam int MAG_W   = SQRT_IT + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    JOB_ACCUM = 2'd0,
    JOB_READ  = 2'd1,
    JOB_CLEAR = 2'd2
  } job_kind_t;

  // for an accumulate job idx carries the cell in its upper bits
  typedef struct packed {
    job_kind_t          kind;
    logic [BIN_AW-1:0]  idx;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RD,
    F_GX,
    F_LAST
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLR,
    B_IDLE,
    B_RD,
    B_RESP,
    B_SQR,
    B_ITER,
    B_RND,
    B_WR
  } back_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/hog_cell_histogram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hog_cell_histogram
// 8-bin gradient orientation histograms over 16x16 cells of a pixel tile.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_index/cfg_data set cells_x (index 0) and cells_y (index 1);
//   the tile size is taken at the next start operation.
//   Input channel (in_valid/in_ready) carries op, pixel and bin_index: a pixel
//   in raster order, a bin read, or a start that clears all bins.
//   Output channel (out_valid/out_ready) returns bin_value for each bin read.
//   A pixel transfer passes the front states F_IDLE, F_RD and F_GX, and also
//   F_LAST on the last row of the tile but its first column, where a second
//   gradient is formed. In the back each gradient runs through B_SQR, the
//   bit-serial square root (13 steps) in B_ITER, B_RND and the read-modify-write
//   of the bin store in B_WR. A bin read passes B_RD and B_RESP. A four-entry
//   job queue lets the front keep taking items while the back works.
//   After reset and after every start the back sweeps all 2048 bins to zero,
//   one per cycle; jobs queued meanwhile wait and the front stalls once the
//   queue is full. A stalled receiver holds the result in the output register;
//   accumulate jobs carry on behind it, only the next read waits.
// ---------------------------------------------------------------------------
module hog_cell_histogram (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [hog_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [hog_pkg::PIX_W-1:0]   pixel,
  input  logic [hog_pkg::BIN_AW-1:0]  bin_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hog_pkg::BIN_W-1:0]   bin_value
);
  import hog_pkg::*;

  job_t push_job, head;
  logic push, push_ready, pop, head_valid;

  hog_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .pixel      (pixel),
    .bin_index  (bin_index),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  hog_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  hog_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bin_value  (bin_value)
  );

endmodule
`default_nettype wire

@@ hw/rtl/hog_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hog_ram
// Generic single write, single read memory with registered read data.
// ---------------------------------------------------------------------------
module hog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/hog_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hog_front
// Takes items, keeps the two-line pixel store and forms the gradient jobs.
// ---------------------------------------------------------------------------
module hog_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [hog_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [hog_pkg::PIX_W-1:0]   pixel,
  input  logic [hog_pkg::BIN_AW-1:0]  bin_index,
  output logic                        push,
  output hog_pkg::job_t               push_job,
  input  logic                        push_ready
);
  import hog_pkg::*;

  front_state_t f_state, f_state_next;

  logic [CFG_W-1:0] cells_x, cells_y;
  logic [CFG_W-1:0] tile_cx;
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;
  logic             tile_done;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;

  logic [PIX_W-1:0] cur, above;
  logic [PIX_W-1:0] s1, s2, first_pix, cur1, cur2;

  logic               line_we;
  logic [LINE_AW-1:0] line_waddr, line_raddr;
  logic [PIX_W-1:0]   line_rdata;

  logic               finish;
  logic [CFG_W-1:0]   cx_clamp, cy_clamp;
  logic [ROW_W-1:0]   row_m1;
  logic [COL_W-1:0]   col_m1, col_p1;
  logic [CELL_W-1:0]  cell1, cell2;
  logic signed [GRAD_W-1:0] gx1, gy1, gx2;

  hog_ram #(
    .WIDTH(PIX_W),
    .DEPTH(2 * LINE_W)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (cur),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  always_comb begin
    cx_clamp = (cells_x == '0) ? CFG_W'(1) :
               (cells_x > CFG_W'(MAX_CELLS_X)) ? CFG_W'(MAX_CELLS_X) : cells_x;
    cy_clamp = (cells_y == '0) ? CFG_W'(1) :
               (cells_y > CFG_W'(MAX_CELLS_Y)) ? CFG_W'(MAX_CELLS_Y) : cells_y;
    row_m1 = row_count - ROW_W'(1);
    col_m1 = col_count - COL_W'(1);
    col_p1 = col_count + COL_W'(1);
    cell1 = CELL_W'((row_m1 >> CELL_SHIFT) * tile_cx + (col_count >> CELL_SHIFT));
    cell2 = CELL_W'((row_count >> CELL_SHIFT) * tile_cx + (col_m1 >> CELL_SHIFT));
    gy1 = $signed({1'b0, cur}) - $signed({1'b0, above});
    gx1 = '0;
    if (col_count != '0 && col_count != last_col) begin
      gx1 = $signed({1'b0, line_rdata}) - $signed({1'b0, s2});
    end
    gx2 = '0;
    if (col_count > COL_W'(1)) begin
      gx2 = $signed({1'b0, cur}) - $signed({1'b0, cur2});
    end
    line_waddr = {row_count[0], col_count};
    // idle: row two above (same slot); afterwards: row above, one column on
    line_raddr = (f_state == F_IDLE) ? {row_count[0], col_count} : {~row_count[0], col_p1};
  end

  always_comb begin
    f_state_next = f_state;
    in_ready     = 1'b0;
    push         = 1'b0;
    push_job     = '0;
    line_we      = 1'b0;
    finish       = 1'b0;
    unique case (f_state)
      F_IDLE: begin
        in_ready = (op_t'(op) == OP_PIXEL) || (op_t'(op) == OP_NONE) || push_ready;
        if (in_valid && in_ready) begin
          unique case (op_t'(op))
            OP_READ: begin
              push          = 1'b1;
              push_job.kind = JOB_READ;
              push_job.idx  = bin_index;
            end
            OP_START: begin
              push          = 1'b1;
              push_job.kind = JOB_CLEAR;
            end
            OP_PIXEL: begin
              if (!tile_done) begin
                f_state_next = F_RD;
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      F_RD: begin
        f_state_next = F_GX;
      end
      F_GX: begin
        line_we = 1'b1;
        if (row_count != '0) begin
          push          = 1'b1;
          push_job.kind = JOB_ACCUM;
          push_job.idx  = {cell1, OCT_W'(0)};
          push_job.gx   = gx1;
          push_job.gy   = gy1;
        end
        if (row_count == '0 || push_ready) begin
          if (row_count == last_row && col_count != '0) begin
            f_state_next = F_LAST;
          end else begin
            finish       = 1'b1;
            f_state_next = F_IDLE;
          end
        end
      end
      F_LAST: begin
        // last row: its gradient has no row below, gy is zero
        push          = 1'b1;
        push_job.kind = JOB_ACCUM;
        push_job.idx  = {cell2, OCT_W'(0)};
        push_job.gx   = gx2;
        push_job.gy   = '0;
        if (push_ready) begin
          finish       = 1'b1;
          f_state_next = F_IDLE;
        end
      end
      default: begin
        f_state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_state <= F_IDLE;
    end else begin
      f_state <= f_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x   <= CFG_W'(1);
      cells_y   <= CFG_W'(1);
      tile_cx   <= CFG_W'(1);
      last_col  <= COL_W'(CELL_SIZE - 1);
      last_row  <= ROW_W'(CELL_SIZE - 1);
      tile_done <= 1'b0;
      row_count <= '0;
      col_count <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) begin
          cells_y <= cfg_data;
        end else begin
          cells_x <= cfg_data;
        end
      end
      if (f_state == F_IDLE && in_valid && in_ready && op_t'(op) == OP_START) begin
        tile_cx   <= cx_clamp;
        last_col  <= COL_W'(cx_clamp * CELL_SIZE - 1);
        last_row  <= ROW_W'(cy_clamp * CELL_SIZE - 1);
        tile_done <= 1'b0;
        row_count <= '0;
        col_count <= '0;
      end
      if (finish) begin
        if (col_count == last_col) begin
          col_count <= '0;
          if (row_count == last_row) begin
            tile_done <= 1'b1;
          end else begin
            row_count <= row_count + ROW_W'(1);
          end
        end else begin
          col_count <= col_p1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f_state == F_IDLE && in_valid && in_ready) begin
      cur <= pixel;
    end
    if (f_state == F_RD) begin
      // second row mirrors the row below for the missing row above
      above <= (row_count == ROW_W'(1)) ? cur : line_rdata;
    end
    if (finish) begin
      // window over the row above: s2 = column c-1, s1 = column c
      if (col_count == '0) begin
        s2        <= first_pix;
        first_pix <= cur;
      end else begin
        s2 <= s1;
      end
      s1   <= line_rdata;
      cur2 <= cur1;
      cur1 <= cur;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hog_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hog_queue
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
module hog_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hog_pkg::job_t push_job,
  output logic          push_ready,
  input  logic          pop,
  output hog_pkg::job_t head,
  output logic          head_valid
);
  import hog_pkg::*;

  job_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_push, do_pop;

  assign push_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job queue popped while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + (QPTR_W + 1)'(1))
    else $error("job queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != (QPTR_W + 1)'(QUEUE_DEPTH)) |-> (wr_ptr - rd_ptr) == count[QPTR_W-1:0])
    else $error("job queue pointers disagree with count");

endmodule
`default_nettype wire

@@ hw/rtl/hog_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hog_back
// Runs jobs on the bin store: clear sweep, bin reads, magnitude accumulate.
// ---------------------------------------------------------------------------
module hog_back (
  input  logic                        clk,
  input  logic                        rst,
  input  hog_pkg::job_t               head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hog_pkg::BIN_W-1:0]   bin_value
);
  import hog_pkg::*;

  back_state_t b_state, b_state_next;

  logic [BIN_AW-1:0]  clr_cnt;
  logic [BIN_AW-1:0]  job_idx;
  logic [PIX_W-1:0]   ax, ay;
  logic [RAD_W-1:0]   rad;
  logic [REM_W-1:0]   rem;
  logic [SQRT_IT-1:0] root;
  logic [IT_W-1:0]    it;
  logic [MAG_W-1:0]   mag;

  logic               bin_we;
  logic [BIN_AW-1:0]  bin_waddr;
  logic [BIN_W-1:0]   bin_wdata, bin_rdata;
  logic [BIN_W:0]     bin_sum;

  logic [PIX_W-1:0]   hax, hay;
  logic [OCT_W-1:0]   hoct;
  logic [SUMSQ_W-1:0] sumsq;
  logic [REM_W-1:0]   rem_sh;
  logic [SQRT_IT+1:0] trial;
  logic               take;
  logic               load_out;

  hog_ram #(
    .WIDTH(BIN_W),
    .DEPTH(BIN_DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (job_idx),
    .rdata (bin_rdata)
  );

  // octant of the head job, decided from signs and |gx| against |gy|
  always_comb begin
    hax = head.gx[GRAD_W-1] ? PIX_W'(-head.gx) : head.gx[PIX_W-1:0];
    hay = head.gy[GRAD_W-1] ? PIX_W'(-head.gy) : head.gy[PIX_W-1:0];
    if (head.gy >= 0 && head.gx > 0) begin
      hoct = (hay < hax) ? OCT_W'(0) : OCT_W'(1);
    end else if (head.gy > 0 && head.gx <= 0) begin
      hoct = (hax < hay) ? OCT_W'(2) : OCT_W'(3);
    end else if (head.gy <= 0 && head.gx < 0) begin
      hoct = (hay < hax) ? OCT_W'(4) : OCT_W'(5);
    end else if (head.gy < 0 && head.gx >= 0) begin
      hoct = (hax < hay) ? OCT_W'(6) : OCT_W'(7);
    end else begin
      hoct = '0;
    end
  end

  always_comb begin
    sumsq   = SUMSQ_W'(ax * ax) + SUMSQ_W'(ay * ay);
    rem_sh  = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial   = {root, 2'b01};
    take    = rem_sh >= REM_W'(trial);
    bin_sum = {1'b0, bin_rdata} + (BIN_W + 1)'(mag);
  end

  always_comb begin
    b_state_next = b_state;
    pop          = 1'b0;
    bin_we       = 1'b0;
    bin_waddr    = job_idx;
    bin_wdata    = '0;
    load_out     = 1'b0;
    unique case (b_state)
      B_CLR: begin
        bin_we    = 1'b1;
        bin_waddr = clr_cnt;
        if (clr_cnt == '1) begin
          b_state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head.kind)
            JOB_ACCUM: b_state_next = B_SQR;
            JOB_READ:  b_state_next = B_RD;
            JOB_CLEAR: b_state_next = B_CLR;
            default:   b_state_next = B_IDLE;
          endcase
        end
      end
      B_RD: begin
        b_state_next = B_RESP;
      end
      B_RESP: begin
        if (!out_valid || out_ready) begin
          load_out     = 1'b1;
          b_state_next = B_IDLE;
        end
      end
      B_SQR: begin
        b_state_next = B_ITER;
      end
      B_ITER: begin
        if (it == '0) begin
          b_state_next = B_RND;
        end
      end
      B_RND: begin
        b_state_next = B_WR;
      end
      B_WR: begin
        bin_we       = 1'b1;
        bin_wdata    = bin_sum[BIN_W] ? '1 : bin_sum[BIN_W-1:0];
        b_state_next = B_IDLE;
      end
      default: begin
        b_state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_state   <= B_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      b_state <= b_state_next;
      if (b_state == B_CLR) begin
        clr_cnt <= clr_cnt + BIN_AW'(1);
      end else if (pop) begin
        clr_cnt <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_idx <= (head.kind == JOB_READ) ? head.idx : {head.idx[BIN_AW-1:OCT_W], hoct};
      ax      <= hax;
      ay      <= hay;
    end
    if (b_state == B_SQR) begin
      rad  <= RAD_W'({sumsq, 8'd0});
      rem  <= '0;
      root <= '0;
      it   <= IT_W'(SQRT_IT - 1);
    end
    if (b_state == B_ITER) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? rem_sh - REM_W'(trial) : rem_sh;
      root <= {root[SQRT_IT-2:0], take};
      it   <= it - IT_W'(1);
    end
    if (b_state == B_RND) begin
      // round to nearest: remainder beyond the root means the upper half
      mag <= MAG_W'(root) + MAG_W'(rem > REM_W'(root));
    end
    if (load_out) begin
      bin_value <= bin_rdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(bin_value))
    else $error("result changed while stalled");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> b_state == B_IDLE)
    else $error("job taken while busy");

  a_clear_wraps: assert property (@(posedge clk) disable iff (rst)
    (b_state == B_CLR && clr_cnt == '1) |=> b_state == B_IDLE)
    else $error("clear sweep did not end at the last bin");

endmodule
`default_nettype wire
